[sv/rcc_pkg.sv]
`timescale 1ns / 1ps

package rcc_pkg;

  // Sizes
  localparam int NUM_CHANNELS  = 14;
  localparam int VALUE_BITS    = 16;
  localparam int CH_BITS       = $clog2(NUM_CHANNELS);
  localparam int SEL_BITS      = 4;
  localparam int NSEL          = 1 << SEL_BITS;
  localparam int CMD_BITS      = 2;
  localparam int RAW_BITS      = 12;
  localparam int TICK_BITS     = 32;
  localparam int SCALE_BITS    = 16;
  localparam int DBAND_BITS    = 11;
  localparam int INV_BITS      = 14;
  localparam int IDX_BITS      = 20;
  localparam int FE_BITS       = 4;
  localparam int MODE_BITS     = 8;
  localparam int SWM_BITS      = 24;
  localparam int GRADE_BITS    = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Conditioning arithmetic: signed raw times unsigned scale, floor shift by ten
  localparam int PROD_BITS = RAW_BITS + SCALE_BITS + 1;
  localparam int SHIFT     = 10;
  localparam int P_BITS    = PROD_BITS - SHIFT;
  localparam int DIFF_BITS = ((P_BITS > VALUE_BITS) ? P_BITS : VALUE_BITS) + 1;

  localparam int VMAX  = (1 << (VALUE_BITS - 1)) - 1;
  localparam int VMIN  = -(1 << (VALUE_BITS - 1));
  localparam int ONE_Q = 1 << 14;
  localparam int FS_INT = (-ONE_Q < VMIN) ? VMIN : -ONE_Q;
  localparam logic signed [VALUE_BITS-1:0] FS_VAL = VALUE_BITS'(FS_INT);

  // Stick and switch thresholds, Q2.14
  localparam int THR_LOW  = -15565;
  localparam int STICK_HI = 14746;
  localparam int STICK_LO = -14746;
  localparam int HALF     = 8192;

  // Link timing, microseconds
  localparam logic [TICK_BITS-1:0] GOOD_LIMIT = TICK_BITS'(100000);
  localparam logic [TICK_BITS-1:0] LOST_LIMIT = TICK_BITS'(1500000);

  // Queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DBAND    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INDICES  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FEATURES = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAFETY   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWITCH   = 3'd6;

  // Feature enable bits
  localparam int FE_CUSTOM = 0;
  localparam int FE_TEST   = 1;
  localparam int FE_GATE   = 2;
  localparam int FE_WING   = 3;

  // Selector slots in channel_indices
  localparam int SLOT_SAFETY = 0;
  localparam int SLOT_MODE   = 1;
  localparam int SLOT_CUSTOM = 2;
  localparam int SLOT_TEST   = 3;
  localparam int SLOT_GATE   = 4;

  // Switch-mode byte positions
  localparam int SW_UP   = 0;
  localparam int SW_MID  = 1;
  localparam int SW_DOWN = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CALIB  = 2'd3
  } cmd_t;

  typedef enum logic [GRADE_BITS-1:0] {
    GRADE_GOOD = 2'd0,
    GRADE_BAD  = 2'd1,
    GRADE_LOST = 2'd2
  } grade_t;

  typedef struct packed {
    logic [SCALE_BITS-1:0] scale;
    logic [DBAND_BITS-1:0] dead_band;
    logic [INV_BITS-1:0]   invert_mask;
    logic [IDX_BITS-1:0]   channel_indices;
    logic [FE_BITS-1:0]    feature_enables;
    logic [MODE_BITS-1:0]  safety_word;
    logic [SWM_BITS-1:0]   switch_modes;
  } cfg_t;

  // Classified request as it waits for the back end
  typedef struct packed {
    cmd_t                     cmd;
    logic [SEL_BITS-1:0]      ch;
    logic                     ch_ok;
    logic                     dz;
    logic signed [P_BITS-1:0] prod;
    logic                     good;
    logic                     bad;
    logic                     lost;
  } qent_t;

  function automatic logic signed [VALUE_BITS-1:0] sat_value(
    input logic signed [DIFF_BITS-1:0] v
  );
    logic signed [DIFF_BITS-1:0] hi;
    logic signed [DIFF_BITS-1:0] lo;
    hi = DIFF_BITS'(VMAX);
    lo = DIFF_BITS'(VMIN);
    if (v > hi) return hi[VALUE_BITS-1:0];
    if (v < lo) return lo[VALUE_BITS-1:0];
    return v[VALUE_BITS-1:0];
  endfunction

endpackage

[sv/rcc_in_if.sv]
`timescale 1ns / 1ps

interface rcc_in_if;
  import rcc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_BITS-1:0]        cmd;
  logic [SEL_BITS-1:0]        channel_index;
  logic signed [RAW_BITS-1:0] raw_value;
  logic [TICK_BITS-1:0]       elapsed_ticks;

  modport source (output valid, cmd, channel_index, raw_value, elapsed_ticks, input ready);
  modport sink   (input valid, cmd, channel_index, raw_value, elapsed_ticks, output ready);
endinterface

[sv/rcc_out_if.sv]
`timescale 1ns / 1ps

interface rcc_out_if;
  import rcc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] channel_value;
  logic [GRADE_BITS-1:0]        link_quality;
  logic [MODE_BITS-1:0]         desired_mode;

  modport source (output valid, channel_value, link_quality, desired_mode, input ready);
  modport sink   (input valid, channel_value, link_quality, desired_mode, output ready);
endinterface

[sv/rcc_front.sv]
`timescale 1ns / 1ps

module rcc_front (
  input  rcc_pkg::cfg_t  cfg,
  rcc_in_if.sink         items,
  input  logic           space,
  output logic           push,
  output rcc_pkg::qent_t entry
);
  import rcc_pkg::*;

  logic signed [SCALE_BITS:0]   scale_s;
  logic signed [PROD_BITS-1:0]  prod_full;
  logic signed [PROD_BITS-1:0]  prod_sh;
  logic signed [P_BITS-1:0]     p;
  logic signed [RAW_BITS:0]     raw_x;
  logic signed [RAW_BITS:0]     dz_x;
  logic [NSEL-1:0]              inv_pad;
  logic                         inv;

  // Handshake: take a request whenever the queue has room
  assign items.ready = space;
  assign push        = items.valid && space;

  // Raw times scale, floor shift into Q2.14
  assign scale_s   = $signed({1'b0, cfg.scale});
  assign prod_full = items.raw_value * scale_s;
  assign prod_sh   = prod_full >>> SHIFT;
  assign p         = prod_sh[P_BITS-1:0];

  // Per-channel inversion; bits beyond the mask read as zero
  assign inv_pad = NSEL'(cfg.invert_mask);
  assign inv     = inv_pad[items.channel_index];

  // Dead zone test in one extra bit so the negated band fits
  assign raw_x = (RAW_BITS+1)'(items.raw_value);
  assign dz_x  = $signed((RAW_BITS+1)'(cfg.dead_band));

  // Classified request
  always_comb begin
    entry.cmd   = cmd_t'(items.cmd);
    entry.ch    = items.channel_index;
    entry.ch_ok = {1'b0, items.channel_index} < (SEL_BITS+1)'(NUM_CHANNELS);
    entry.dz    = (raw_x < dz_x) && (raw_x > -dz_x);
    entry.prod  = inv ? -p : p;
    entry.good  = items.elapsed_ticks < GOOD_LIMIT;
    entry.bad   = items.elapsed_ticks < LOST_LIMIT;
    entry.lost  = items.elapsed_ticks > LOST_LIMIT;
  end

endmodule

[sv/rcc_queue.sv]
`timescale 1ns / 1ps

module rcc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcc_pkg::qent_t din,
  output logic           space,
  input  logic           pop,
  output rcc_pkg::qent_t dout,
  output logic           valid
);
  import rcc_pkg::*;

  qent_t                mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign space = count < QCNT_BITS'(QDEPTH);
  assign valid = count != '0;
  assign dout  = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QDEPTH))
    else $error("queue count beyond depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

[sv/rcc_back.sv]
`timescale 1ns / 1ps

module rcc_back (
  input  logic           clk,
  input  logic           rst,
  input  rcc_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  rcc_pkg::qent_t head,
  output logic           pop,
  rcc_out_if.source      results
);
  import rcc_pkg::*;

  logic signed [VALUE_BITS-1:0] channel_store [NUM_CHANNELS];
  logic signed [VALUE_BITS-1:0] trim_store    [NUM_CHANNELS];
  grade_t                       link_grade;
  logic [MODE_BITS-1:0]         mode_word;

  logic                         fire;
  logic [CH_BITS-1:0]           idx;
  logic signed [VALUE_BITS-1:0] trim_rd;
  logic signed [VALUE_BITS-1:0] chan_rd;
  logic signed [DIFF_BITS-1:0]  s_diff;
  logic signed [DIFF_BITS-1:0]  c_diff;
  logic signed [VALUE_BITS-1:0] cv;
  logic                         failsafe;
  logic                         run_rule;
  grade_t                       grade_next;

  logic signed [VALUE_BITS-1:0] eff [NSEL];
  logic [NSEL-1:0]              gt0;
  logic [NSEL-1:0]              ge_half;
  logic [NSEL-1:0]              gt_nhalf;
  logic [SEL_BITS-1:0]          sel_safety, sel_mode, sel_custom, sel_test, sel_gate;
  logic                         t_low, y_lo, y_hi, p_hi, r_hi, r_lo;
  logic                         armed;
  logic [MODE_BITS-1:0]         nm;
  logic [MODE_BITS-1:0]         mode_next;

  // Advance when a request waits and the output register is free or draining
  assign fire = q_valid && (!results.valid || results.ready);
  assign pop  = fire;

  assign idx     = head.ch[CH_BITS-1:0];
  assign trim_rd = trim_store[idx];
  assign chan_rd = channel_store[idx];

  // Sample and calibrate values
  assign s_diff   = DIFF_BITS'(head.prod) - DIFF_BITS'(trim_rd);
  assign c_diff   = DIFF_BITS'(chan_rd) - DIFF_BITS'(trim_rd);
  assign failsafe = (head.cmd == CMD_TICK) && head.lost;
  assign run_rule = (head.cmd == CMD_FRAME) || (head.cmd == CMD_TICK);

  always_comb begin
    cv = '0;
    if (head.ch_ok) begin
      if (head.cmd == CMD_SAMPLE) begin
        cv = head.dz ? '0 : sat_value(s_diff);
      end else if (head.cmd == CMD_CALIB) begin
        cv = sat_value(c_diff);
      end
    end
  end

  // Link grade
  always_comb begin
    grade_next = link_grade;
    if (head.cmd == CMD_FRAME) begin
      if (head.good) begin
        grade_next = GRADE_GOOD;
      end else if (head.bad) begin
        grade_next = GRADE_BAD;
      end
    end else if (failsafe) begin
      grade_next = GRADE_LOST;
    end
  end

  // Channel values as the mode rule sees them: failsafe applies first,
  // selectors past the last channel read zero
  always_comb begin
    for (int i = 0; i < NSEL; i++) begin
      eff[i] = '0;
    end
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      eff[i] = failsafe ? '0 : channel_store[i];
    end
    if (failsafe) begin
      eff[0] = FS_VAL;
    end
    for (int i = 0; i < NSEL; i++) begin
      gt0[i]      = eff[i] > 0;
      ge_half[i]  = eff[i] >= HALF;
      gt_nhalf[i] = eff[i] > -HALF;
    end
  end

  assign sel_safety = cfg.channel_indices[SLOT_SAFETY*SEL_BITS +: SEL_BITS];
  assign sel_mode   = cfg.channel_indices[SLOT_MODE*SEL_BITS +: SEL_BITS];
  assign sel_custom = cfg.channel_indices[SLOT_CUSTOM*SEL_BITS +: SEL_BITS];
  assign sel_test   = cfg.channel_indices[SLOT_TEST*SEL_BITS +: SEL_BITS];
  assign sel_gate   = cfg.channel_indices[SLOT_GATE*SEL_BITS +: SEL_BITS];

  // Sticks: throttle 0, roll 1, pitch 2, yaw 3
  assign t_low = eff[0] <= THR_LOW;
  assign r_hi  = eff[1] >= STICK_HI;
  assign r_lo  = eff[1] <= STICK_LO;
  assign p_hi  = eff[2] >= STICK_HI;
  assign y_hi  = eff[3] >= STICK_HI;
  assign y_lo  = eff[3] <= STICK_LO;

  // Arming by stick combination
  always_comb begin
    armed = mode_word[MODE_BITS-1];
    if (cfg.feature_enables[FE_WING]) begin
      if (t_low && y_lo) begin
        armed = 1'b1;
      end else if (t_low && y_hi) begin
        armed = 1'b0;
      end
    end else begin
      if (t_low && y_lo && p_hi && r_hi) begin
        armed = 1'b1;
      end else if (t_low && y_hi && p_hi && r_lo) begin
        armed = 1'b0;
      end
    end
  end

  // Mode rule: safety switch, three-position switch, custom and test bits, gate hold
  always_comb begin
    if (gt0[sel_safety]) begin
      nm = {armed, cfg.safety_word[MODE_BITS-2:0]};
    end else begin
      if (ge_half[sel_mode]) begin
        nm = cfg.switch_modes[SW_UP*MODE_BITS +: MODE_BITS];
      end else if (gt_nhalf[sel_mode]) begin
        nm = cfg.switch_modes[SW_MID*MODE_BITS +: MODE_BITS];
      end else begin
        nm = cfg.switch_modes[SW_DOWN*MODE_BITS +: MODE_BITS];
      end
      if (cfg.feature_enables[FE_CUSTOM]) begin
        nm[0] = gt0[sel_custom];
      end
      if (cfg.feature_enables[FE_TEST]) begin
        nm[1] = gt0[sel_test];
      end
      // switch path may only keep an existing arm, never set one
      nm[MODE_BITS-1] = armed && mode_word[MODE_BITS-1];
    end
    mode_next = (cfg.feature_enables[FE_GATE] && !ge_half[sel_gate]) ? mode_word : nm;
  end

  // Channel and trim stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_store[i] <= '0;
        trim_store[i]    <= '0;
      end
    end else if (fire) begin
      if (failsafe) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          channel_store[i] <= '0;
        end
        channel_store[0] <= FS_VAL;
      end else if (head.ch_ok && head.cmd == CMD_SAMPLE) begin
        channel_store[idx] <= cv;
      end else if (head.ch_ok && head.cmd == CMD_CALIB) begin
        trim_store[idx] <= cv;
      end
    end
  end

  // Link grade and mode word
  always_ff @(posedge clk) begin
    if (rst) begin
      link_grade <= GRADE_GOOD;
      mode_word  <= '0;
    end else if (fire) begin
      link_grade <= grade_next;
      if (run_rule) begin
        mode_word <= mode_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (fire) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      results.channel_value <= cv;
      results.link_quality  <= grade_next;
      results.desired_mode  <= run_rule ? mode_next : mode_word;
    end
  end

  a_sample_keeps_mode: assert property (@(posedge clk) disable iff (rst)
    fire && head.cmd == CMD_SAMPLE |=> $stable(mode_word))
    else $error("mode word moved on a sample");

  a_failsafe_lost: assert property (@(posedge clk) disable iff (rst)
    fire && failsafe |=> link_grade == GRADE_LOST && channel_store[0] == FS_VAL)
    else $error("failsafe did not take effect");

  a_fire_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> results.valid)
    else $error("executed request produced no result");

endmodule

[sv/rc_channel_conditioner_mode_select_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// items     in   valid / ready          cmd, channel_index, raw_value, elapsed_ticks
// results   out  valid / ready          channel_value, link_quality, desired_mode
// cfg       in   cfg_write (no stall)   cfg_index, cfg_data
//
// One request per cycle sustained while results are not stalled; a taken request
// enters the queue and its result is registered on leaving it (multiply and
// classification ahead of the queue, store update and mode rule in the back).
// rst is synchronous: stores, trims, link grade, mode word and registers are loaded
// with their reset values directly, no clearing pass.
// A two-entry queue parts front and back; items.ready falls only when it is full
// while results are stalled.
module rc_channel_conditioner_mode_select_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rcc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  rcc_in_if.sink                             items,
  rcc_out_if.source                          results
);
  import rcc_pkg::*;

  cfg_t  cfg;
  qent_t f_entry;
  qent_t q_head;
  logic  f_push;
  logic  q_space;
  logic  q_valid;
  logic  b_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale           <= SCALE_BITS'(19065);
      cfg.dead_band       <= DBAND_BITS'(30);
      cfg.invert_mask     <= '0;
      cfg.channel_indices <= '0;
      cfg.feature_enables <= '0;
      cfg.safety_word     <= '0;
      cfg.switch_modes    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCALE:    cfg.scale           <= cfg_data[SCALE_BITS-1:0];
        CFG_DBAND:    cfg.dead_band       <= cfg_data[DBAND_BITS-1:0];
        CFG_INVERT:   cfg.invert_mask     <= cfg_data[INV_BITS-1:0];
        CFG_INDICES:  cfg.channel_indices <= cfg_data[IDX_BITS-1:0];
        CFG_FEATURES: cfg.feature_enables <= cfg_data[FE_BITS-1:0];
        CFG_SAFETY:   cfg.safety_word     <= cfg_data[MODE_BITS-1:0];
        CFG_SWITCH:   cfg.switch_modes    <= cfg_data[SWM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  rcc_front u_front (
    .cfg   (cfg),
    .items (items),
    .space (q_space),
    .push  (f_push),
    .entry (f_entry)
  );

  rcc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_entry),
    .space (q_space),
    .pop   (b_pop),
    .dout  (q_head),
    .valid (q_valid)
  );

  rcc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .head    (q_head),
    .pop     (b_pop),
    .results (results)
  );

endmodule

[test/tb_rc_channel_conditioner_mode_select_core.sv]
`timescale 1ns / 1ps

module tb_rc_channel_conditioner_mode_select_core;
  import rcc_pkg::*;

  // Timing and run length
  localparam int CLK_HALF_NS = 5;
  localparam int RESET_CYCLES = 5;
  localparam longint TIMEOUT_NS = 64'd5_000_000;
  localparam int NUM_PHASES = 10;

  // Receiver semantics, Q2.14 and microseconds
  localparam longint Q_POS_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
  localparam longint Q_NEG_MIN = -(64'sd1 <<< (VALUE_BITS - 1));
  localparam longint FAILSAFE_THROTTLE = -16384;
  localparam longint ARM_THROTTLE_MAX = -15565;
  localparam longint STICK_FAR_POS = 14746;
  localparam longint STICK_FAR_NEG = -14746;
  localparam longint SWITCH_HALF = 8192;
  localparam logic [TICK_BITS-1:0] LINK_GOOD_US = 32'd100000;
  localparam logic [TICK_BITS-1:0] LINK_LOST_US = 32'd1500000;

  // Stick channels
  localparam int THROTTLE_CH = 0;
  localparam int ROLL_CH = 1;
  localparam int PITCH_CH = 2;
  localparam int YAW_CH = 3;

  typedef enum int {LVL_LOW, LVL_MID, LVL_HIGH} lvl_t;

  typedef struct {
    cmd_t                       cmd;
    logic [SEL_BITS-1:0]        ch;
    logic signed [RAW_BITS-1:0] raw;
    logic [TICK_BITS-1:0]       ticks;
  } rc_req_t;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    grade_t                       grade;
    logic [MODE_BITS-1:0]         mode;
  } rc_resp_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  rcc_in_if items_if ();
  rcc_out_if results_if ();

  rc_channel_conditioner_mode_select_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_if),
    .results   (results_if)
  );

  // Predictor state: registers, channel and trim stores, link grade, mode word
  cfg_t cur_cfg;
  logic signed [VALUE_BITS-1:0] chan_q [NUM_CHANNELS];
  logic signed [VALUE_BITS-1:0] trim_q [NUM_CHANNELS];
  grade_t link_q;
  logic [MODE_BITS-1:0] mode_q;

  rc_req_t req_backlog [$];
  rc_resp_t cond_results_q [$];
  rc_req_t live_req;
  rc_resp_t want;

  int fail_cnt;
  int stim_count;
  bit flow_free;
  int burst_left;
  int gap_left;
  logic [15:0] stall_bits;
  int stall_pos;

  always #CLK_HALF_NS clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic signed [VALUE_BITS-1:0] clamp_q(longint v);
    if (v > Q_POS_MAX) return VALUE_BITS'(Q_POS_MAX);
    if (v < Q_NEG_MIN) return VALUE_BITS'(Q_NEG_MIN);
    return VALUE_BITS'(v);
  endfunction

  function automatic logic [SEL_BITS-1:0] selector(int pos);
    return cur_cfg.channel_indices[pos*SEL_BITS +: SEL_BITS];
  endfunction

  // Selectors past the last channel read as zero
  function automatic longint sel_value(logic [SEL_BITS-1:0] idx);
    if (idx >= NUM_CHANNELS) return 0;
    return longint'(chan_q[idx]);
  endfunction

  function automatic logic arm_decision();
    longint thr, rol, pit, yaw;
    logic armed;
    thr = sel_value(SEL_BITS'(THROTTLE_CH));
    rol = sel_value(SEL_BITS'(ROLL_CH));
    pit = sel_value(SEL_BITS'(PITCH_CH));
    yaw = sel_value(SEL_BITS'(YAW_CH));
    armed = mode_q[7];
    if (cur_cfg.feature_enables[FE_WING]) begin
      if (thr <= ARM_THROTTLE_MAX && yaw <= STICK_FAR_NEG) armed = 1'b1;
      else if (thr <= ARM_THROTTLE_MAX && yaw >= STICK_FAR_POS) armed = 1'b0;
    end else begin
      if (thr <= ARM_THROTTLE_MAX && yaw <= STICK_FAR_NEG &&
          pit >= STICK_FAR_POS && rol >= STICK_FAR_POS)
        armed = 1'b1;
      else if (thr <= ARM_THROTTLE_MAX && yaw >= STICK_FAR_POS &&
               pit >= STICK_FAR_POS && rol <= STICK_FAR_NEG)
        armed = 1'b0;
    end
    return armed;
  endfunction

  function automatic void select_mode();
    logic [MODE_BITS-1:0] nm;
    logic flag;
    longint sw;
    // closed gate freezes the mode word
    if (cur_cfg.feature_enables[FE_GATE] && sel_value(selector(SLOT_GATE)) < SWITCH_HALF)
      return;
    flag = arm_decision();
    if (sel_value(selector(SLOT_SAFETY)) > 0) begin
      nm = {flag, cur_cfg.safety_word[6:0]};
    end else begin
      sw = sel_value(selector(SLOT_MODE));
      if (sw >= SWITCH_HALF) nm = cur_cfg.switch_modes[SW_UP*8 +: 8];
      else if (sw > -SWITCH_HALF) nm = cur_cfg.switch_modes[SW_MID*8 +: 8];
      else nm = cur_cfg.switch_modes[SW_DOWN*8 +: 8];
      if (cur_cfg.feature_enables[FE_CUSTOM]) nm[0] = sel_value(selector(SLOT_CUSTOM)) > 0;
      if (cur_cfg.feature_enables[FE_TEST]) nm[1] = sel_value(selector(SLOT_TEST)) > 0;
      // outside safety arming can only be kept, never gained
      nm[7] = flag & mode_q[7];
    end
    mode_q = nm;
  endfunction

  function automatic void condition_request(rc_req_t r);
    rc_resp_t o;
    longint rv, dz, prod;
    o.value = '0;
    case (r.cmd)
      CMD_SAMPLE: begin
        if (r.ch < NUM_CHANNELS) begin
          rv = r.raw;
          dz = cur_cfg.dead_band;
          if (!(rv < dz && rv > -dz)) begin
            prod = (rv * longint'(cur_cfg.scale)) >>> 10;
            if (cur_cfg.invert_mask[r.ch]) prod = -prod;
            o.value = clamp_q(prod - longint'(trim_q[r.ch]));
          end
          chan_q[r.ch] = o.value;
        end
      end
      CMD_FRAME: begin
        if (r.ticks < LINK_GOOD_US) link_q = GRADE_GOOD;
        else if (r.ticks < LINK_LOST_US) link_q = GRADE_BAD;
        select_mode();
      end
      CMD_TICK: begin
        // failsafe: throttle fully down, everything else centered
        if (r.ticks > LINK_LOST_US) begin
          chan_q[THROTTLE_CH] = clamp_q(FAILSAFE_THROTTLE);
          for (int i = 1; i < NUM_CHANNELS; i++) chan_q[i] = '0;
          link_q = GRADE_LOST;
        end
        select_mode();
      end
      default: begin
        if (r.ch < NUM_CHANNELS) begin
          o.value = clamp_q(longint'(chan_q[r.ch]) - longint'(trim_q[r.ch]));
          trim_q[r.ch] = o.value;
        end
      end
    endcase
    o.grade = link_q;
    o.mode = mode_q;
    cond_results_q.push_back(o);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic int rand_raw();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic void add_req(cmd_t c, int ch, int raw, logic [TICK_BITS-1:0] t);
    rc_req_t r;
    r.cmd = c;
    r.ch = SEL_BITS'(ch);
    r.raw = RAW_BITS'(raw);
    r.ticks = t;
    req_backlog.push_back(r);
    if (!((c == CMD_SAMPLE || c == CMD_CALIB) && ch >= NUM_CHANNELS)) stim_count++;
  endfunction

  function automatic logic [TICK_BITS-1:0] pick_ticks();
    logic [TICK_BITS-1:0] t;
    case ($urandom_range(0, 5))
      0, 1: t = $urandom_range(0, LINK_GOOD_US - 1);
      2: t = $urandom_range(LINK_GOOD_US, LINK_LOST_US - 1);
      3: t = $urandom;
      4: begin
        case ($urandom_range(0, 4))
          0: t = LINK_GOOD_US - 1;
          1: t = LINK_GOOD_US;
          2: t = LINK_LOST_US - 1;
          3: t = LINK_LOST_US;
          default: t = LINK_LOST_US + 1;
        endcase
      end
      default: t = $urandom_range(LINK_LOST_US + 1, 2 * LINK_LOST_US);
    endcase
    return t;
  endfunction

  // Sample that puts a channel far high, far low or centered, honoring inversion
  function automatic void queue_level(int ch, lvl_t lvl);
    int raw, db;
    db = int'(cur_cfg.dead_band);
    case (lvl)
      LVL_HIGH: raw = $urandom_range(1500, 2047);
      LVL_LOW: raw = -int'($urandom_range(1500, 2047));
      default: raw = (db > 1) ? int'($urandom_range(0, 2 * (db - 1))) - (db - 1) : 0;
    endcase
    if (ch < NUM_CHANNELS && lvl != LVL_MID && cur_cfg.invert_mask[ch]) raw = -raw;
    add_req(CMD_SAMPLE, ch, raw, $urandom);
  endfunction

  function automatic void queue_frame_end();
    logic [TICK_BITS-1:0] t;
    if ($urandom_range(0, 3) == 0) t = pick_ticks();
    else t = $urandom_range(0, LINK_GOOD_US - 1);
    add_req(($urandom_range(0, 4) == 0) ? CMD_TICK : CMD_FRAME,
            $urandom_range(0, 15), rand_raw(), t);
  endfunction

  // Well-formed stick and switch sequences closed by a frame end
  function automatic void queue_gesture();
    int kind;
    kind = $urandom_range(0, 5);
    case (kind)
      0: begin
        // arm with safety up
        if (cur_cfg.feature_enables[FE_GATE]) queue_level(selector(SLOT_GATE), LVL_HIGH);
        queue_level(selector(SLOT_SAFETY), LVL_HIGH);
        queue_level(THROTTLE_CH, LVL_LOW);
        queue_level(YAW_CH, LVL_LOW);
        queue_level(PITCH_CH, LVL_HIGH);
        queue_level(ROLL_CH, LVL_HIGH);
      end
      1: begin
        // disarm, safety anywhere
        if (cur_cfg.feature_enables[FE_GATE]) queue_level(selector(SLOT_GATE), LVL_HIGH);
        queue_level(selector(SLOT_SAFETY), lvl_t'($urandom_range(0, 2)));
        queue_level(THROTTLE_CH, LVL_LOW);
        queue_level(YAW_CH, LVL_HIGH);
        queue_level(PITCH_CH, LVL_HIGH);
        queue_level(ROLL_CH, LVL_LOW);
      end
      2: begin
        // mode switch walk with safety down
        queue_level(selector(SLOT_GATE),
                    ($urandom_range(0, 3) != 0) ? LVL_HIGH : lvl_t'($urandom_range(0, 2)));
        queue_level(selector(SLOT_SAFETY), lvl_t'($urandom_range(0, 1)));
        queue_level(selector(SLOT_MODE), lvl_t'($urandom_range(0, 2)));
        queue_level(selector(SLOT_CUSTOM), lvl_t'($urandom_range(0, 2)));
        queue_level(selector(SLOT_TEST), lvl_t'($urandom_range(0, 2)));
      end
      3: begin
        for (int i = THROTTLE_CH; i <= YAW_CH; i++) queue_level(i, LVL_MID);
      end
      4: begin
        queue_level(selector(SLOT_SAFETY), LVL_HIGH);
      end
      default: begin
        // silence, then the link comes back
        add_req(CMD_TICK, $urandom_range(0, 15), rand_raw(),
                $urandom_range(LINK_LOST_US + 1, 5_000_000));
        queue_level($urandom_range(0, NUM_CHANNELS - 1), lvl_t'($urandom_range(0, 2)));
      end
    endcase
    queue_frame_end();
  endfunction

  function automatic void queue_single();
    int sel, ch;
    sel = $urandom_range(0, 99);
    ch = $urandom_range(0, 15);
    if (sel < 45) add_req(CMD_SAMPLE, ch, rand_raw(), $urandom);
    else if (sel < 65) add_req(CMD_FRAME, ch, rand_raw(), pick_ticks());
    else if (sel < 85) add_req(CMD_TICK, ch, rand_raw(), pick_ticks());
    else begin
      add_req(CMD_CALIB, ch, rand_raw(), $urandom);
      // second pass restores a stick trim so gestures keep working
      if (ch <= YAW_CH) add_req(CMD_CALIB, ch, rand_raw(), $urandom);
    end
  endfunction

  function automatic void fill_random(int n);
    stim_count = 0;
    while (stim_count < n) begin
      if ($urandom_range(0, 99) < 55) queue_gesture();
      else queue_single();
    end
  endfunction

  function automatic void queue_directed();
    // dead band edges and raw extremes
    add_req(CMD_SAMPLE, 0, 0, 32'h0);
    add_req(CMD_SAMPLE, 1, 29, 32'hFFFF_FFFF);
    add_req(CMD_SAMPLE, 2, -30, 32'h0);
    add_req(CMD_SAMPLE, 3, 30, 32'h0);
    add_req(CMD_SAMPLE, 13, -2048, 32'h0);
    // channel past the last one is ignored
    add_req(CMD_SAMPLE, 14, 2047, 32'h0);
    add_req(CMD_SAMPLE, 15, -1, 32'h0);
    add_req(CMD_CALIB, 15, 0, 32'h0);
    // saturation of conditioned value and of the new trim, both ways
    add_req(CMD_SAMPLE, 5, 2047, 32'h0);
    add_req(CMD_CALIB, 5, 0, 32'h0);
    add_req(CMD_SAMPLE, 5, -2048, 32'h0);
    add_req(CMD_CALIB, 5, 0, 32'h0);
    add_req(CMD_SAMPLE, 5, 2047, 32'h0);
    add_req(CMD_CALIB, 5, -2048, 32'h0);
    // link grading around both limits
    add_req(CMD_FRAME, 0, 0, 32'd0);
    add_req(CMD_FRAME, 0, 0, LINK_GOOD_US - 1);
    add_req(CMD_FRAME, 0, 0, LINK_GOOD_US);
    add_req(CMD_FRAME, 0, 0, LINK_LOST_US - 1);
    add_req(CMD_FRAME, 0, 0, LINK_LOST_US);
    // failsafe only strictly beyond the limit
    add_req(CMD_TICK, 0, 0, LINK_LOST_US);
    add_req(CMD_TICK, 0, 0, LINK_LOST_US + 1);
    add_req(CMD_FRAME, 15, 2047, 32'hFFFF_FFFF);
    add_req(CMD_TICK, 15, -2048, 32'hFFFF_FFFF);
    add_req(CMD_SAMPLE, 10, 1365, 32'h5555_AAAA);
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes, only while idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SCALE: cur_cfg.scale = data[SCALE_BITS-1:0];
      CFG_DBAND: cur_cfg.dead_band = data[DBAND_BITS-1:0];
      CFG_INVERT: cur_cfg.invert_mask = data[INV_BITS-1:0];
      CFG_INDICES: cur_cfg.channel_indices = data[IDX_BITS-1:0];
      CFG_FEATURES: cur_cfg.feature_enables = data[FE_BITS-1:0];
      CFG_SAFETY: cur_cfg.safety_word = data[MODE_BITS-1:0];
      CFG_SWITCH: cur_cfg.switch_modes = data[SWM_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_SCALE, CFG_DATA_BITS'(c.scale));
    write_reg(CFG_DBAND, CFG_DATA_BITS'(c.dead_band));
    write_reg(CFG_INVERT, CFG_DATA_BITS'(c.invert_mask));
    write_reg(CFG_INDICES, CFG_DATA_BITS'(c.channel_indices));
    write_reg(CFG_FEATURES, CFG_DATA_BITS'(c.feature_enables));
    write_reg(CFG_SAFETY, CFG_DATA_BITS'(c.safety_word));
    write_reg(CFG_SWITCH, CFG_DATA_BITS'(c.switch_modes));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    if ($urandom_range(0, 3) == 0) c.scale = SCALE_BITS'($urandom);
    else c.scale = SCALE_BITS'($urandom_range(12000, 40000));
    if ($urandom_range(0, 3) == 0) c.dead_band = DBAND_BITS'($urandom);
    else c.dead_band = DBAND_BITS'($urandom_range(0, 200));
    c.invert_mask = INV_BITS'($urandom);
    // selectors mostly on non-stick channels, now and then out of range
    for (int k = 0; k < 5; k++)
      c.channel_indices[k*SEL_BITS +: SEL_BITS] = ($urandom_range(0, 7) == 0) ?
          SEL_BITS'($urandom_range(0, 15)) : SEL_BITS'($urandom_range(4, NUM_CHANNELS - 1));
    c.feature_enables = FE_BITS'($urandom);
    c.safety_word = MODE_BITS'($urandom);
    c.switch_modes = SWM_BITS'($urandom);
    return c;
  endfunction

  // Idle: nothing waiting, nothing on the bus, nothing outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (req_backlog.size() != 0 || items_if.valid || cond_results_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (items_if.valid && items_if.ready) condition_request(live_req);
      if (!(items_if.valid && !items_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          items_if.valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          live_req = req_backlog.pop_front();
          items_if.valid <= 1'b1;
          items_if.cmd <= live_req.cmd;
          items_if.channel_index <= live_req.ch;
          items_if.raw_value <= live_req.raw;
          items_if.elapsed_ticks <= live_req.ticks;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = (flow_free || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stalls follow a rotating 16-bit pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_pos = 0;
    end else begin
      if (stall_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_bits = '1;
          1: stall_bits = 16'($urandom);
          default: stall_bits = 16'($urandom) | 16'($urandom);
        endcase
      end
      results_if.ready <= flow_free || stall_bits[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (cond_results_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        want = cond_results_q.pop_front();
        if (results_if.channel_value !== want.value) begin
          $error("channel_value: expected %0d, got %0d", want.value, results_if.channel_value);
          fail_cnt++;
        end
        if (results_if.link_quality !== want.grade) begin
          $error("link_quality: expected %0d, got %0d", want.grade,
                 results_if.link_quality);
          fail_cnt++;
        end
        if (results_if.desired_mode !== want.mode) begin
          $error("desired_mode: expected 0x%02h, got 0x%02h", want.mode,
                 results_if.desired_mode);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests, then phases of register settings
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t c;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    flow_free = 1'b0;

    // register and store values after reset
    cur_cfg = '0;
    cur_cfg.scale = 16'd19065;
    cur_cfg.dead_band = 11'd30;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_q[i] = '0;
      trim_q[i] = '0;
    end
    link_q = GRADE_GOOD;
    mode_q = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    fill_random(150);
    wait_idle();

    for (int ph = 1; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: c = '1;
        2: c = '0;
        default: c = random_cfg();
      endcase
      program_regs(c);
      flow_free = (ph == 5);
      fill_random((ph < 3) ? 150 : 170);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $error("run did not complete in time");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
sv/rcc_pkg.sv
sv/rcc_in_if.sv
sv/rcc_out_if.sv
sv/rcc_front.sv
sv/rcc_queue.sv
sv/rcc_back.sv
sv/rc_channel_conditioner_mode_select_core.sv
test/tb_rc_channel_conditioner_mode_select_core.sv
